>>> src/isfd_pkg.sv
// ============================================================================
// isfd_pkg: shared types and constants for the serial frame deframer
// Holds the sync byte value, byte width and the packed result beat layout.
// ============================================================================
`timescale 1ns / 1ps

package isfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;

  // Sync value that opens every frame
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

  typedef logic [BYTE_W-1:0] byte_t;

  // Result beat, first member in the highest bits: frame_type lands in [7:0]
  typedef struct packed {
    logic [WORD_W-1:0] word_three;
    logic [WORD_W-1:0] word_two;
    logic [WORD_W-1:0] word_one;
    logic [WORD_W-1:0] word_zero;
    byte_t             frame_type;
  } result_t;

  // Per-cell control from the window controller
  typedef struct packed {
    logic en;     // input beat accepted this cycle
    logic sel;    // this cell sits at the fill position
    logic shift;  // slide the window left by one byte
  } cell_ctl_t;

endpackage

>>> src/isfd_cell.sv
// ============================================================================
// isfd_cell: one byte slot of the frame window
// Takes the incoming byte at the fill position and hands its byte to the
// left neighbor when the window slides.
// ============================================================================
`timescale 1ns / 1ps

module isfd_cell (
  input  logic                clk,
  input  isfd_pkg::byte_t     rx_byte,
  input  isfd_pkg::cell_ctl_t ctl,
  input  isfd_pkg::byte_t     nbr_byte,   // written byte of the right neighbor
  output isfd_pkg::byte_t     wr_byte     // this slot after the incoming write
);

  isfd_pkg::byte_t slot;

  // Show the slot as it stands once the incoming byte is placed
  assign wr_byte = ctl.sel ? rx_byte : slot;

  // Shift in the neighbor's byte, or capture the incoming byte
  always_ff @(posedge clk) begin
    if (ctl.en && ctl.shift) begin
      slot <= nbr_byte;
    end else if (ctl.en && ctl.sel) begin
      slot <= rx_byte;
    end
  end

endmodule

>>> src/isfd_out_buf.sv
// ============================================================================
// isfd_out_buf: registered output with a skid slot
// Holds one result beat for the downstream side and parks one more, so the
// upstream ready is a register and never waits on the downstream ready.
// ============================================================================
`timescale 1ns / 1ps

module isfd_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  isfd_pkg::result_t     in_data,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output isfd_pkg::result_t     out_data
);

  logic              skid_valid;
  isfd_pkg::result_t skid_data;
  logic              take_in;
  logic              out_free;

  assign in_ready = !skid_valid;
  assign take_in  = in_valid && !skid_valid;
  assign out_free = !out_valid || out_ready;

  // Track occupancy of the output and skid slots
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_in) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // Move payload along with the occupancy
  always_ff @(posedge clk) begin
    if (take_in) begin
      if (out_free) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end else if (out_free && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

>>> src/imu_serial_frame_deframer_unit.sv
// ============================================================================
// imu_serial_frame_deframer_unit: sync-byte deframer with additive checksum
// Collects serial bytes in a row of byte cells, hunts for the 0x55 sync,
// checks the modulo-256 sum and emits type byte plus four 16-bit words.
//
//   channel  | dir | tdata fields (low bit up)                  | tuser
//   s_axis   | in  | rx_byte[7:0]                               | -
//   m_axis   | out | word_zero, word_one, word_two, word_three  | frame_type
//
// One byte is taken every cycle while s_axis_tready is high; the window cells,
// fill count and running checksum all settle in the cycle of the beat.
// A good frame shows on m_axis the cycle after its checksum byte when the
// output slot is free or draining; otherwise it waits in the skid slot.
// Reset clears the fill count, the running sum and the output slots; the
// byte cells keep whatever they hold.
// s_axis_tready drops only while both output slots hold unclaimed results.
// ============================================================================
`timescale 1ns / 1ps

module imu_serial_frame_deframer_unit #(
  parameter int unsigned FRAME_LEN = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] word_zero, [31:16] word_one,
                                      // [47:32] word_two, [63:48] word_three
  output logic [7:0]  m_axis_tuser    // [7:0] frame_type
);

  localparam int unsigned FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int unsigned OUT_BYTES = 10;

  isfd_pkg::byte_t     rx_byte;
  isfd_pkg::byte_t     wr_bytes [FRAME_LEN];
  isfd_pkg::byte_t     frm_bytes [OUT_BYTES];
  isfd_pkg::cell_ctl_t ctl [FRAME_LEN];

  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   fill_count_next;
  logic [FILL_W-1:0]   fill_inc;
  isfd_pkg::byte_t     sum_acc;
  isfd_pkg::byte_t     sum_acc_next;

  logic                accept;
  logic                no_sync;
  logic                full;
  logic                slide;
  logic                emit;
  logic                buf_ready;
  isfd_pkg::result_t   result;
  isfd_pkg::result_t   out_res;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = buf_ready;
  assign accept        = s_axis_tvalid && buf_ready;

  // Row of byte cells, each handing its byte to the left neighbor
  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
    assign ctl[i].en    = accept;
    assign ctl[i].sel   = (fill_count == FILL_W'(i));
    assign ctl[i].shift = slide;

    if (i == FRAME_LEN - 1) begin : g_last
      isfd_cell u_cell (
        .clk      (clk),
        .rx_byte  (rx_byte),
        .ctl      (ctl[i]),
        .nbr_byte (wr_bytes[i]),
        .wr_byte  (wr_bytes[i])
      );
    end else begin : g_mid
      isfd_cell u_cell (
        .clk      (clk),
        .rx_byte  (rx_byte),
        .ctl      (ctl[i]),
        .nbr_byte (wr_bytes[i+1]),
        .wr_byte  (wr_bytes[i])
      );
    end
  end

  // Decide slide, wait or emit from the window after the incoming write
  always_comb begin
    fill_inc        = fill_count + FILL_W'(1);
    no_sync         = (wr_bytes[0] != isfd_pkg::SYNC_BYTE);
    full            = (fill_inc == FILL_W'(FRAME_LEN));
    slide           = 1'b0;
    emit            = 1'b0;
    fill_count_next = fill_inc;
    sum_acc_next    = sum_acc + rx_byte;
    if (no_sync || (full && (sum_acc != rx_byte))) begin
      slide           = 1'b1;
      fill_count_next = fill_count;
      sum_acc_next    = sum_acc + rx_byte - wr_bytes[0];
    end else if (full) begin
      emit            = 1'b1;
      fill_count_next = '0;
      sum_acc_next    = '0;
    end
  end

  // Hold the fill count and the running sum of the held bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      sum_acc    <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      sum_acc    <= sum_acc_next;
    end
  end

  // Pick frame bytes; bytes from the checksum position on read as zero
  for (genvar k = 0; k < OUT_BYTES; k++) begin : g_frm
    if (k < FRAME_LEN - 1) begin : g_real
      assign frm_bytes[k] = wr_bytes[k];
    end else begin : g_zero
      assign frm_bytes[k] = '0;
    end
  end

  assign result.frame_type = frm_bytes[1];
  assign result.word_zero  = {frm_bytes[3], frm_bytes[2]};
  assign result.word_one   = {frm_bytes[5], frm_bytes[4]};
  assign result.word_two   = {frm_bytes[7], frm_bytes[6]};
  assign result.word_three = {frm_bytes[9], frm_bytes[8]};

  isfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && emit),
    .in_data   (result),
    .in_ready  (buf_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // Split the result beat into the word data and the type sideband
  assign m_axis_tdata = {out_res.word_three, out_res.word_two,
                         out_res.word_one, out_res.word_zero};
  assign m_axis_tuser = out_res.frame_type;

endmodule

>>> dv/imu_serial_frame_deframer_unit_tb.sv
// ============================================================================
// imu_serial_frame_deframer_unit_tb: self-checking bench for the deframer
// Feeds serial bytes (noise, good frames, frames with a broken checksum and
// cut-off frames) under random input gaps and output stalls. A byte-level
// window predictor builds the expected frames, and every output beat is
// compared field by field with the oldest one still due.
// ============================================================================
`timescale 1ns / 1ps

module imu_serial_frame_deframer_unit_tb;

  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned BYTE_TARGET = 1800;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned DRAIN_WAIT  = 8;

  // Predicts frames from the accepted byte stream and checks output beats
  class frame_scoreboard;
    isfd_pkg::byte_t   win [FRAME_LEN];
    int unsigned       fill;
    isfd_pkg::result_t frames_due [$];
    int unsigned       errors;
    int unsigned       frames_seen;
    int unsigned       bytes_seen;
    int unsigned       bad_sums;

    function new();
      fill = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    // Drop the oldest byte of the window
    function void slide();
      for (int i = 0; i + 1 < FRAME_LEN; i++) win[i] = win[i+1];
      if (fill > 0) fill--;
    endfunction

    function void note_byte(isfd_pkg::byte_t b);
      isfd_pkg::byte_t   sum;
      isfd_pkg::result_t r;
      bytes_seen++;
      if (fill >= FRAME_LEN) fill = 0;
      win[fill] = b;
      fill++;
      // hunt for the sync byte
      if (win[0] != isfd_pkg::SYNC_BYTE) begin
        slide();
        return;
      end
      if (fill < FRAME_LEN) return;
      sum = '0;
      for (int i = 0; i + 1 < FRAME_LEN; i++) sum += win[i];
      if (sum != win[FRAME_LEN-1]) begin
        bad_sums++;
        slide();
        return;
      end
      r.frame_type = win[1];
      r.word_zero  = {win[3], win[2]};
      r.word_one   = {win[5], win[4]};
      r.word_two   = {win[7], win[6]};
      r.word_three = {win[9], win[8]};
      frames_due.push_back(r);
      fill = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(isfd_pkg::result_t got);
      isfd_pkg::result_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("frame with no frame due, type %02h", got.frame_type));
        return;
      end
      want = frames_due.pop_front();
      frames_seen++;
      if (got.frame_type != want.frame_type)
        report($sformatf("frame_type got %02h want %02h",
                         got.frame_type, want.frame_type));
      if (got.word_zero != want.word_zero)
        report($sformatf("word_zero got %04h want %04h",
                         got.word_zero, want.word_zero));
      if (got.word_one != want.word_one)
        report($sformatf("word_one got %04h want %04h",
                         got.word_one, want.word_one));
      if (got.word_two != want.word_two)
        report($sformatf("word_two got %04h want %04h",
                         got.word_two, want.word_two));
      if (got.word_three != want.word_three)
        report($sformatf("word_three got %04h want %04h",
                         got.word_three, want.word_three));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [15:0] word_zero, [31:16] word_one,
                               // [47:32] word_two, [63:48] word_three
  logic [7:0]  m_axis_tuser;   // [7:0] frame_type

  frame_scoreboard sb;
  isfd_pkg::byte_t frame_buf [FRAME_LEN];
  int unsigned     bytes_sent;
  int unsigned     burst_left;
  bit              steady;
  bit              hold_off_req;
  int unsigned     in_stall_cycles;
  int unsigned     idle_cycles;

  imu_serial_frame_deframer_unit #(
    .FRAME_LEN(FRAME_LEN)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(isfd_pkg::result_t'({m_axis_tdata, m_axis_tuser}));
    end
  end

  // End the run when neither channel moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] timeout: no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("** imu_serial_frame_deframer_unit: FAILED **");
    $finish;
  end

  // Receiver: a periodically redrawn random stall pattern, plus one long hold
  initial begin
    int unsigned  phase;
    logic [15:0]  stall_mask;
    phase         = 0;
    stall_mask    = '0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (phase % 64 == 0)
        stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
      m_axis_tready <= ~stall_mask[phase % 16];
      phase++;
    end
  end

  // Offer one byte, with a random gap at the start of each burst unless steady is set
  task automatic send_byte(input isfd_pkg::byte_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Fill the payload, leaning toward all-zero, all-one and sync bytes
  function automatic void random_payload();
    for (int i = 2; i + 1 < FRAME_LEN; i++) begin
      case ($urandom_range(0, 9))
        0:       frame_buf[i] = 8'h00;
        1:       frame_buf[i] = 8'hFF;
        2:       frame_buf[i] = isfd_pkg::SYNC_BYTE;
        default: frame_buf[i] = isfd_pkg::byte_t'($urandom);
      endcase
    end
  endfunction

  // Send the first keep bytes of a frame built around the payload in frame_buf
  task automatic send_frame(input isfd_pkg::byte_t ftype, input bit corrupt,
                            input int unsigned keep);
    isfd_pkg::byte_t sum;
    frame_buf[0] = isfd_pkg::SYNC_BYTE;
    frame_buf[1] = ftype;
    sum = '0;
    for (int i = 0; i + 1 < FRAME_LEN; i++) sum += frame_buf[i];
    frame_buf[FRAME_LEN-1] = corrupt ?
        (sum ^ isfd_pkg::byte_t'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < keep; i++) send_byte(frame_buf[i]);
  endtask

  initial begin
    int unsigned pick;
    bit          hold_done;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    bytes_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    hold_off_req  = 1'b0;
    hold_done     = 1'b0;
    in_stall_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: noise extremes, a good all-ones frame, then a broken frame
    // whose payload carries a sync byte that the slide must find
    send_byte(8'h00);
    send_byte(8'hFF);
    for (int i = 2; i + 1 < FRAME_LEN; i++) frame_buf[i] = 8'hFF;
    send_frame(8'hFF, 1'b0, FRAME_LEN);
    for (int i = 2; i + 1 < FRAME_LEN; i++) frame_buf[i] = 8'h00;
    frame_buf[2] = isfd_pkg::SYNC_BYTE;
    send_frame(8'h00, 1'b1, FRAME_LEN);

    // Random: mostly good frames, some broken, cut off, or noise
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 15) == 0) steady = ~steady;
      if (!hold_done && bytes_sent > 600) begin
        // Stall the output for a long stretch while good frames keep coming
        hold_done    = 1'b1;
        hold_off_req = 1'b1;
        repeat (6) begin
          random_payload();
          send_frame(isfd_pkg::byte_t'($urandom), 1'b0, FRAME_LEN);
        end
      end
      pick = $urandom_range(0, 99);
      random_payload();
      if (pick < 65)
        send_frame(isfd_pkg::byte_t'($urandom), 1'b0, FRAME_LEN);
      else if (pick < 78)
        send_frame(isfd_pkg::byte_t'($urandom), 1'b1, FRAME_LEN);
      else if (pick < 88)
        send_frame(isfd_pkg::byte_t'($urandom), 1'b0,
                   $urandom_range(1, FRAME_LEN - 1));
      else
        repeat ($urandom_range(1, 4)) send_byte(isfd_pkg::byte_t'($urandom));
    end
    s_axis_tvalid <= 1'b0;

    // Drain every frame still due, then watch for stray beats before the summary
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d bytes, %0d frames checked, %0d broken checksums seen,",
             sb.bytes_seen, sb.frames_seen, sb.bad_sums);
    $display("with %0d input stall cycles and one long output hold.", in_stall_cycles);
    if (sb.errors == 0) begin
      $display("** imu_serial_frame_deframer_unit: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** imu_serial_frame_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> imu_serial_frame_deframer_unit.f
src/isfd_pkg.sv
src/isfd_cell.sv
src/isfd_out_buf.sv
src/imu_serial_frame_deframer_unit.sv
dv/imu_serial_frame_deframer_unit_tb.sv
